// ===== design/gbf_pkg.sv =====
// Shared constants, types and codes for the graph bridge finder.
package gbf_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned VTX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned EADDR_W      = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W        = $clog2(MAX_EDGES + 1);
  localparam int unsigned POS_W        = CNT_W + 1;
  localparam int unsigned TIME_W       = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SP_W         = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned STATUS_W     = 2;

  // Item actions
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RUN = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_BRIDGE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BRIDGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD,
    ST_CHK,
    ST_LOW,
    ST_POP,
    ST_POPW,
    ST_POPB,
    ST_POPL,
    ST_FIN1,
    ST_FIN2
  } gbf_state_e;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } gbf_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]    bridge_from;
    logic [VTX_W-1:0]    bridge_to;
    logic [STATUS_W-1:0] status;
    logic                last;
  } gbf_res_t;

  // One level of the walk stack
  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] disc;
    logic [TIME_W-1:0] low;
    logic [VTX_W-1:0]  parent;
  } gbf_frame_t;

endpackage

// ===== design/gbf_in_if.sv =====
// Input item channel.
interface gbf_in_if;
  import gbf_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;
  modport source (output valid, output action, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input action, input vertex_a, input vertex_b, output ready);
endinterface

// ===== design/gbf_out_if.sv =====
// Result channel.
interface gbf_out_if;
  import gbf_pkg::*;
  logic                valid;
  logic                ready;
  logic [VTX_W-1:0]    bridge_from;
  logic [VTX_W-1:0]    bridge_to;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, output bridge_from, output bridge_to, output status,
                  output last, input ready);
  modport sink   (input valid, input bridge_from, input bridge_to, input status,
                  input last, output ready);
endinterface

// ===== design/gbf_cfg_if.sv =====
// Configuration write channel.
interface gbf_cfg_if;
  import gbf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/gbf_min_unit.sv =====
// Shared compare unit: less-than flag and minimum of two times.
module gbf_min_unit import gbf_pkg::*; (
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  output logic              lt_o,
  output logic [TIME_W-1:0] min_o
);

  assign lt_o  = (a_i < b_i);
  assign min_o = lt_o ? a_i : b_i;

endmodule

// ===== design/gbf_core.sv =====
// Sequencer for edge loading and the stack-based bridge search.
module gbf_core import gbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] vcount_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gbf_item_t        in_item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output gbf_res_t         res_o
);

  gbf_state_e state_q, state_d;

  logic [SP_W-1:0]         sp_q, sp_d;
  logic [VTX_W-1:0]        cur_u_q, cur_u_d;
  logic [POS_W-1:0]        cur_pos_q, cur_pos_d;
  logic [TIME_W-1:0]       cur_disc_q, cur_disc_d;
  logic [TIME_W-1:0]       cur_low_q, cur_low_d;
  logic [VTX_W-1:0]        cur_par_q, cur_par_d;
  logic [TIME_W-1:0]       child_low_q, child_low_d;
  logic [VTX_W-1:0]        child_u_q, child_u_d;
  logic [TIME_W-1:0]       time_q, time_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic                    dropped_q, dropped_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [VTX_W-1:0]        pend_from_q, pend_from_d;
  logic [VTX_W-1:0]        pend_to_q, pend_to_d;

  // Memories
  logic [2*VTX_W-1:0] edge_mem [MAX_EDGES];
  logic [2*VTX_W-1:0] edge_rd_q;
  logic               edge_we;
  logic [EADDR_W-1:0] edge_waddr;
  logic [EADDR_W-1:0] edge_raddr;

  logic [TIME_W-1:0]  disc_mem [MAX_VERTICES];
  logic [TIME_W-1:0]  disc_rd_q;
  logic               disc_we;
  logic [VTX_W-1:0]   disc_addr;
  logic [TIME_W-1:0]  disc_wdata;

  gbf_frame_t         stk_mem [MAX_VERTICES];
  gbf_frame_t         stk_rd_q;
  gbf_frame_t         stk_wdata;
  logic               stk_we;
  logic [VTX_W-1:0]   stk_waddr;
  logic [VTX_W-1:0]   stk_raddr;

  logic [TIME_W-1:0]  n_eff;
  logic [VTX_W-1:0]   e_a, e_b, nb;
  logic               e_ok, e_match;
  logic [SP_W-1:0]    sp_m1, sp_m2;
  logic [TIME_W-1:0]  cmp_a, cmp_b, cmp_min;
  logic               cmp_lt;

  // Clamp the vertex count to 1..MAX_VERTICES
  always_comb begin
    if (vcount_i == '0) begin
      n_eff = TIME_W'(1);
    end else if (TIME_W'(vcount_i) > TIME_W'(MAX_VERTICES)) begin
      n_eff = TIME_W'(MAX_VERTICES);
    end else begin
      n_eff = TIME_W'(vcount_i);
    end
  end

  // Decode the stored edge at the current scan position
  assign e_a     = edge_rd_q[2*VTX_W-1:VTX_W];
  assign e_b     = edge_rd_q[VTX_W-1:0];
  assign e_ok    = (TIME_W'(e_a) < n_eff) && (TIME_W'(e_b) < n_eff);
  assign e_match = cur_pos_q[0] ? (e_b == cur_u_q) : (e_a == cur_u_q);
  assign nb      = cur_pos_q[0] ? e_a : e_b;
  assign sp_m1   = sp_q - SP_W'(1);
  assign sp_m2   = sp_q - SP_W'(2);

  // Shared compare unit operand select
  always_comb begin
    case (state_q)
      ST_POPB: begin
        cmp_a = cur_disc_q;
        cmp_b = child_low_q;
      end
      ST_POPL: begin
        cmp_a = child_low_q;
        cmp_b = cur_low_q;
      end
      default: begin
        cmp_a = disc_rd_q;
        cmp_b = cur_low_q;
      end
    endcase
  end

  gbf_min_unit u_min (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .lt_o  (cmp_lt),
    .min_o (cmp_min)
  );

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    cur_u_d      = cur_u_q;
    cur_pos_d    = cur_pos_q;
    cur_disc_d   = cur_disc_q;
    cur_low_d    = cur_low_q;
    cur_par_d    = cur_par_q;
    child_low_d  = child_low_q;
    child_u_d    = child_u_q;
    time_d       = time_q;
    visited_d    = visited_q;
    total_d      = total_q;
    dropped_d    = dropped_q;
    pend_valid_d = pend_valid_q;
    pend_from_d  = pend_from_q;
    pend_to_d    = pend_to_q;

    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    edge_we      = 1'b0;
    edge_waddr   = total_q[EADDR_W-1:0];
    edge_raddr   = cur_pos_q[EADDR_W:1];
    disc_we      = 1'b0;
    disc_addr    = nb;
    disc_wdata   = time_q;
    stk_we       = 1'b0;
    stk_waddr    = sp_m1[VTX_W-1:0];
    stk_raddr    = sp_m2[VTX_W-1:0];
    stk_wdata    = '{vertex: cur_u_q, pos: cur_pos_q + POS_W'(1), disc: cur_disc_q,
                     low: cur_low_q, parent: cur_par_q};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_item_i.action == ACT_RUN) begin
            state_d = ST_INIT;
          end else if ((TIME_W'(in_item_i.vertex_a) >= n_eff) ||
                       (TIME_W'(in_item_i.vertex_b) >= n_eff) ||
                       (total_q >= CNT_W'(MAX_EDGES))) begin
            dropped_d = 1'b1;
          end else begin
            edge_we = 1'b1;
            total_d = total_q + CNT_W'(1);
          end
        end
      end

      // Start the walk at vertex zero
      ST_INIT: begin
        visited_d    = MAX_VERTICES'(1);
        disc_we      = 1'b1;
        disc_addr    = '0;
        disc_wdata   = '0;
        cur_u_d      = '0;
        cur_pos_d    = '0;
        cur_disc_d   = '0;
        cur_low_d    = '0;
        cur_par_d    = '0;
        time_d       = TIME_W'(1);
        sp_d         = SP_W'(1);
        pend_valid_d = 1'b0;
        state_d      = ST_RD;
      end

      // Fetch the edge at the scan position, or finish this vertex
      ST_RD: begin
        if (cur_pos_q >= {total_q, 1'b0}) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_CHK;
        end
      end

      ST_CHK: begin
        cur_pos_d = cur_pos_q + POS_W'(1);
        state_d   = ST_RD;
        if (e_ok && e_match) begin
          if (!visited_q[nb]) begin
            // Push the current level and descend
            stk_we          = 1'b1;
            visited_d[nb]   = 1'b1;
            disc_we         = 1'b1;
            cur_u_d         = nb;
            cur_pos_d       = '0;
            cur_disc_d      = time_q;
            cur_low_d       = time_q;
            cur_par_d       = cur_u_q;
            time_d          = time_q + TIME_W'(1);
            sp_d            = sp_q + SP_W'(1);
          end else if (cur_par_q != nb) begin
            state_d = ST_LOW;
          end
        end
      end

      // Back edge: take the smaller of the neighbor's discovery time and the current low
      ST_LOW: begin
        cur_low_d = cmp_min;
        state_d   = ST_RD;
      end

      ST_POP: begin
        sp_d        = sp_m1;
        child_low_d = cur_low_q;
        child_u_d   = cur_u_q;
        if (sp_q == SP_W'(1)) begin
          state_d = ST_FIN1;
        end else begin
          state_d = ST_POPW;
        end
      end

      ST_POPW: begin
        cur_u_d    = stk_rd_q.vertex;
        cur_pos_d  = stk_rd_q.pos;
        cur_disc_d = stk_rd_q.disc;
        cur_low_d  = stk_rd_q.low;
        cur_par_d  = stk_rd_q.parent;
        state_d    = ST_POPB;
      end

      // Bridge test; hold the newest bridge so the last flag can be set later
      ST_POPB: begin
        state_d = ST_POPL;
        if (cmp_lt) begin
          if (pend_valid_q) begin
            res_valid_o = 1'b1;
            res_o       = '{bridge_from: pend_from_q, bridge_to: pend_to_q,
                            status: STATUS_BRIDGE, last: 1'b0};
            if (res_ready_i) begin
              pend_from_d = cur_u_q;
              pend_to_d   = child_u_q;
            end else begin
              state_d = ST_POPB;
            end
          end else begin
            pend_valid_d = 1'b1;
            pend_from_d  = cur_u_q;
            pend_to_d    = child_u_q;
          end
        end
      end

      ST_POPL: begin
        cur_low_d = cmp_min;
        state_d   = ST_RD;
      end

      ST_FIN1: begin
        res_valid_o = 1'b1;
        if (pend_valid_q) begin
          res_o = '{bridge_from: pend_from_q, bridge_to: pend_to_q,
                    status: STATUS_BRIDGE, last: !dropped_q};
        end else begin
          res_o = '{bridge_from: '0, bridge_to: '0,
                    status: STATUS_NO_BRIDGE, last: !dropped_q};
        end
        if (res_ready_i) begin
          if (dropped_q) begin
            state_d = ST_FIN2;
          end else begin
            total_d = '0;
            state_d = ST_IDLE;
          end
        end
      end

      ST_FIN2: begin
        res_valid_o = 1'b1;
        res_o       = '{bridge_from: '0, bridge_to: '0, status: STATUS_DROPPED, last: 1'b1};
        if (res_ready_i) begin
          total_d   = '0;
          dropped_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sp_q         <= '0;
      time_q       <= '0;
      visited_q    <= '0;
      total_q      <= '0;
      dropped_q    <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      sp_q         <= sp_d;
      time_q       <= time_d;
      visited_q    <= visited_d;
      total_q      <= total_d;
      dropped_q    <= dropped_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers of the current level
  always_ff @(posedge clk_i) begin
    cur_u_q     <= cur_u_d;
    cur_pos_q   <= cur_pos_d;
    cur_disc_q  <= cur_disc_d;
    cur_low_q   <= cur_low_d;
    cur_par_q   <= cur_par_d;
    child_low_q <= child_low_d;
    child_u_q   <= child_u_d;
    pend_from_q <= pend_from_d;
    pend_to_q   <= pend_to_d;
  end

  // Edge store
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= {in_item_i.vertex_a, in_item_i.vertex_b};
    end
    edge_rd_q <= edge_mem[edge_raddr];
  end

  // Discovery times
  always_ff @(posedge clk_i) begin
    if (disc_we) begin
      disc_mem[disc_addr] <= disc_wdata;
    end
    disc_rd_q <= disc_mem[disc_addr];
  end

  // Walk stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

endmodule

// ===== design/graph_bridge_finder.sv =====
// Top level of the graph bridge finder.
//
//  channel | dir | handshake     | payload
//  cfg_ch  | in  | valid / ready | data = vertex_count
//  in_ch   | in  | valid / ready | action, vertex_a, vertex_b
//  out_ch  | out | valid / ready | bridge_from, bridge_to, status, last
//
// Edge loads may arrive back to back. A run starts with an init step; each vertex
// on the stack then takes a fetch and a check step per scanned edge side, a fetch
// step to see its list end, an extra step per back edge, and the pop, restore,
// bridge-test and low-update steps to return to its parent (vertex 0 goes to the
// close); one or two results end the run. The edge store has a single read port.
// in_ch.ready is low for the whole run. A stalled out_ch holds the sequencer.
// Reset clears the control state; the vertex count resets to 64.
module graph_bridge_finder import gbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbf_cfg_if.sink   cfg_ch,
  gbf_in_if.sink    in_ch,
  gbf_out_if.source out_ch
);

  logic [CFG_W-1:0] vcount_q;
  gbf_item_t        item;
  gbf_res_t         res, out_q;
  logic             res_valid, res_ready;
  logic             out_valid_q;

  // Vertex count register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CFG_W'(MAX_VERTICES);
    end else if (cfg_ch.valid) begin
      vcount_q <= cfg_ch.data;
    end
  end

  assign item = '{action: in_ch.action, vertex_a: in_ch.vertex_a, vertex_b: in_ch.vertex_b};

  gbf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vcount_i    (vcount_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load on a transfer from the core
  assign res_ready = !out_valid_q || out_ch.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.bridge_from = out_q.bridge_from;
  assign out_ch.bridge_to   = out_q.bridge_to;
  assign out_ch.status      = out_q.status;
  assign out_ch.last        = out_q.last;

endmodule

// ===== design/gbf_checker.sv =====
// Port-level checks for the graph bridge finder, bound to the top level.
module gbf_checker import gbf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_action,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_last
);

  // An accepted run lowers input ready
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_action == ACT_RUN) |=> !in_ready)
    else $error("input ready after run transfer");

  // Status code three is never produced
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status == STATUS_BRIDGE || out_status == STATUS_NO_BRIDGE ||
                   out_status == STATUS_DROPPED))
    else $error("bad status");

  // Drop report closes a run
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status == STATUS_DROPPED) |-> out_last)
    else $error("drop report not last");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_last)))
    else $error("result changed under stall");

endmodule

bind graph_bridge_finder gbf_checker u_gbf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

// ===== verif/tb_graph_bridge_finder.sv =====
// Self-checking testbench for the graph bridge finder: directed table, then random graphs.
`timescale 1ns / 100ps

module tb_graph_bridge_finder;
  import gbf_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {TYPED_NONE, TYPED_NO_BRIDGE, TYPED_NB_DROP} typed_e;

  typedef struct {
    row_kind_e        kind;
    logic             action;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic [CFG_W-1:0] cfg;
    typed_e           typed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   no_idle = 1'b0;
  int   error_count = 0;

  gbf_cfg_if cfg_ch ();
  gbf_in_if  in_ch ();
  gbf_out_if out_ch ();

  graph_bridge_finder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // Mirror of the block state
  logic [CFG_W-1:0] vcount_reg = 7'd64;
  logic [VTX_W-1:0] store_a [MAX_EDGES];
  logic [VTX_W-1:0] store_b [MAX_EDGES];
  int               store_total = 0;
  bit               store_dropped = 1'b0;
  gbf_res_t         bridge_q [$];
  row_t             rows [$];

  function automatic int eff_vertices();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
    return int'(vcount_reg);
  endfunction

  function automatic gbf_res_t mk_res(int from, int to, logic [STATUS_W-1:0] st, logic lst);
    gbf_res_t r;
    r.bridge_from = from[VTX_W-1:0];
    r.bridge_to   = to[VTX_W-1:0];
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  // Walk from vertex 0 with an explicit stack and list the bridges found
  function automatic void search_bridges(ref gbf_res_t found [$]);
    int  n;
    int  sp;
    int  tick;
    int  u;
    int  w;
    int  nb;
    int  p;
    bit  hit;
    bit  seen [MAX_VERTICES];
    int  disc [MAX_VERTICES];
    int  low [MAX_VERTICES];
    int  par [MAX_VERTICES];
    int  stk_v [MAX_VERTICES];
    int  stk_p [MAX_VERTICES];
    n = eff_vertices();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      seen[i] = 1'b0;
      par[i] = i;
    end
    seen[0] = 1'b1;
    disc[0] = 0;
    low[0] = 0;
    tick = 1;
    stk_v[0] = 0;
    stk_p[0] = 0;
    sp = 1;
    while (sp > 0) begin
      u = stk_v[sp-1];
      hit = 1'b0;
      for (p = stk_p[sp-1]; p < 2 * store_total; p++) begin
        if (store_a[p>>1] >= n || store_b[p>>1] >= n) continue;
        if (p[0] == 1'b0 && store_a[p>>1] == u) begin
          nb = int'(store_b[p>>1]);
          hit = 1'b1;
          break;
        end
        if (p[0] == 1'b1 && store_b[p>>1] == u) begin
          nb = int'(store_a[p>>1]);
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        stk_p[sp-1] = p + 1;
        if (!seen[nb]) begin
          par[nb] = u;
          seen[nb] = 1'b1;
          disc[nb] = tick;
          low[nb] = tick;
          tick++;
          stk_v[sp] = nb;
          stk_p[sp] = 0;
          sp++;
        end else if (par[u] != nb && disc[nb] < low[u]) begin
          low[u] = disc[nb];
        end
      end else begin
        sp--;
        if (sp > 0) begin
          w = stk_v[sp-1];
          if (low[u] < low[w]) low[w] = low[u];
          if (low[u] > disc[w]) found = {found, mk_res(w, u, STATUS_BRIDGE, 1'b0)};
        end
      end
    end
  endfunction

  // Apply one accepted item to the mirror; queue the results of a run
  task automatic predict_item(logic act, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                              typed_e typed);
    gbf_res_t found [$];
    if (act == ACT_ADD) begin
      if (va >= eff_vertices() || vb >= eff_vertices() || store_total >= MAX_EDGES) begin
        store_dropped = 1'b1;
      end else begin
        store_a[store_total] = va;
        store_b[store_total] = vb;
        store_total++;
      end
      return;
    end
    search_bridges(found);
    if (found.size() == 0) found = {found, mk_res(0, 0, STATUS_NO_BRIDGE, 1'b0)};
    if (store_dropped) found = {found, mk_res(0, 0, STATUS_DROPPED, 1'b0)};
    found[found.size()-1].last = 1'b1;
    // Hand-written expectations take the place of the predicted ones
    if (typed == TYPED_NO_BRIDGE) begin
      found = {mk_res(0, 0, STATUS_NO_BRIDGE, 1'b1)};
    end else if (typed == TYPED_NB_DROP) begin
      found = {mk_res(0, 0, STATUS_NO_BRIDGE, 1'b0), mk_res(0, 0, STATUS_DROPPED, 1'b1)};
    end
    bridge_q = {bridge_q, found};
    store_total = 0;
    store_dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Sender: optional random gap, then hold the transfer until accepted
  task automatic send_item(logic act, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                           typed_e typed);
    if (!no_idle && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.vertex_a <= va;
    in_ch.vertex_b <= vb;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(act, va, vb, typed);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (bridge_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vcount(logic [CFG_W-1:0] value);
    wait_drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    vcount_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_row(row_kind_e k, logic act, int va, int vb, int cfg,
                                  typed_e typed);
    row_t r;
    r.kind = k;
    r.action = act;
    r.va = va[VTX_W-1:0];
    r.vb = vb[VTX_W-1:0];
    r.cfg = cfg[CFG_W-1:0];
    r.typed = typed;
    rows = {rows, r};
  endfunction

  // Result checker and random back-pressure
  always @(posedge clk_i) begin
    gbf_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (bridge_q.size() == 0) begin
        report_mismatch("unexpected result status", int'(out_ch.status), -1);
      end else begin
        want = bridge_q.pop_front();
        if (out_ch.bridge_from !== want.bridge_from)
          report_mismatch("bridge_from", int'(out_ch.bridge_from), int'(want.bridge_from));
        if (out_ch.bridge_to !== want.bridge_to)
          report_mismatch("bridge_to", int'(out_ch.bridge_to), int'(want.bridge_to));
        if (out_ch.status !== want.status)
          report_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.last !== want.last)
          report_mismatch("last", int'(out_ch.last), int'(want.last));
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 8);
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    int span;
    int edges;
    int va;
    int vb;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    add_row(ROW_ITEM, ACT_RUN, 63, 63, 0, TYPED_NO_BRIDGE);   // empty graph after reset
    add_row(ROW_CFG, ACT_ADD, 0, 0, 2, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 0, 1, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NONE);          // lone edge is a bridge
    add_row(ROW_CFG, ACT_ADD, 0, 0, 64, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 63, 63, 0, TYPED_NONE);        // self-loop
    add_row(ROW_ITEM, ACT_ADD, 0, 63, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 63, 0, 0, TYPED_NONE);         // parallel edge to parent
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NONE);
    add_row(ROW_CFG, ACT_ADD, 0, 0, 3, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 5, 1, 0, TYPED_NONE);          // bad endpoint
    add_row(ROW_ITEM, ACT_ADD, 0, 1, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 1, 2, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 2, 0, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NB_DROP);       // triangle plus drop
    add_row(ROW_CFG, ACT_ADD, 0, 0, 0, TYPED_NONE);           // zero acts as one
    add_row(ROW_ITEM, ACT_ADD, 0, 0, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 1, 0, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NB_DROP);
    add_row(ROW_CFG, ACT_ADD, 0, 0, 127, TYPED_NONE);         // clamps to the maximum
    add_row(ROW_ITEM, ACT_ADD, 62, 63, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 0, 62, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 0, 1, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 1, 40, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 40, 0, 0, TYPED_NONE);
    add_row(ROW_ITEM, ACT_ADD, 1, 2, 0, TYPED_NONE);
    add_row(ROW_CFG, ACT_ADD, 0, 0, 10, TYPED_NONE);          // lowered after loading
    add_row(ROW_ITEM, ACT_RUN, 0, 0, 0, TYPED_NONE);
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_vcount(rows[i].cfg);
      else send_item(rows[i].action, rows[i].va, rows[i].vb, rows[i].typed);
    end

    // Random graphs: mostly connected ones grown from vertex 0
    for (int g = 0; g < 24; g++) begin
      no_idle = (g >= 8 && g < 12);
      if (g % 3 == 0) begin
        case ($urandom_range(0, 5))
          0: write_vcount(7'd64);
          1: write_vcount(7'($urandom_range(65, 127)));
          2: write_vcount(7'd0);
          default: write_vcount(7'($urandom_range(1, 64)));
        endcase
      end
      if (g == 15) wait_drain();
      n = eff_vertices();
      span = $urandom_range(1, n);
      edges = $urandom_range(0, 14);
      for (int e = 0; e < edges; e++) begin
        if ($urandom_range(0, 99) < 8) begin
          va = $urandom_range(0, 63);
          vb = $urandom_range(0, 63);
        end else begin
          vb = $urandom_range(0, span - 1);
          va = (e < span - 1 && $urandom_range(0, 1)) ? e + 1 : $urandom_range(0, span - 1);
          if ($urandom_range(0, 1)) va = (va == 0) ? 0 : $urandom_range(0, va - 1);
        end
        send_item(ACT_ADD, VTX_W'(va), VTX_W'(vb), TYPED_NONE);
      end
      send_item(ACT_RUN, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)),
                TYPED_NONE);
    end
    no_idle = 1'b0;

    wait_drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
